// File: rtl/assert_macros.svh
// Assertion macros shared by the timer expiry queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");

// Condition a implies condition b in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");

`endif

// File: rtl/tmq_pkg.sv
// Package for the timer expiry queue: field widths, parameter defaults,
// operation and result codes. No dependencies.
`default_nettype none

package tmq_pkg;

   localparam int CAPACITY_DEF  = 16;
   localparam int MAX_FIRE_DEF  = 63;
   localparam int TIME_BITS_DEF = 48;

   localparam int IN_TIME_W = 48;
   localparam int ID_W      = 32;
   localparam int CNT_W     = 6;
   localparam int DUE_W     = 49;
   localparam int FUNC_W    = 2;
   localparam int KIND_W    = 3;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXPIRE = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd2;
   localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_SUMMARY   = 3'd5;

endpackage

`default_nettype wire

// File: rtl/tmq_cell.sv
// One slot of the circulating timer ring: valid, id, expiry and period.
// Depends on tmq_pkg.
`default_nettype none

module tmq_cell import tmq_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 shift,
   input  wire logic                 d_valid,
   input  wire logic [ID_W-1:0]      d_id,
   input  wire logic [TIME_BITS-1:0] d_exp,
   input  wire logic [TIME_BITS-1:0] d_per,
   output logic                      q_valid,
   output logic [ID_W-1:0]           q_id,
   output logic [TIME_BITS-1:0]      q_exp,
   output logic [TIME_BITS-1:0]      q_per
);

   logic                 valid_ff;
   logic                 valid_in;
   logic [ID_W-1:0]      id_ff;
   logic [TIME_BITS-1:0] exp_ff;
   logic [TIME_BITS-1:0] per_ff;

   assign valid_in = shift ? d_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         id_ff  <= d_id;
         exp_ff <= d_exp;
         per_ff <= d_per;
      end
   end

   assign q_valid = valid_ff;
   assign q_id    = id_ff;
   assign q_exp   = exp_ff;
   assign q_per   = per_ff;

endmodule

`default_nettype wire

// File: rtl/timer_expiry_queue.sv
// Top level of the timer expiry queue: a ring of tmq_cell slots that
// circulates past one head stage, plus the sequencer and output register.
// Depends on tmq_pkg, tmq_cell and assert_macros.svh.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | func, expiry_time, period, timer_key, now_time
//   rsp     | out       | rsp_valid / rsp_ready  | kind, result_id, fired_count, next_due,
//           |           |                        | more_due, last
//
// Every item takes one full turn of the ring per pass past the head cell.
// Add and remove: an accept, one scan turn of the ring, then a result.
// Expire: one turn per fired timer plus one more, each followed by a result.
// An unknown func is only accepted; it starts no scan and returns no result.
// Reset empties all slots and sets the id counter to 1.
// A stalled result holds the ring between turns until the transfer completes.
`default_nettype none

module timer_expiry_queue import tmq_pkg::*; #(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int MAX_FIRE  = MAX_FIRE_DEF,
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [FUNC_W-1:0]    req_func,
   input  wire logic [IN_TIME_W-1:0] req_expiry_time,
   input  wire logic [IN_TIME_W-1:0] req_period,
   input  wire logic [ID_W-1:0]      req_timer_key,
   input  wire logic [IN_TIME_W-1:0] req_now_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [KIND_W-1:0]         rsp_kind,
   output logic [ID_W-1:0]           rsp_result_id,
   output logic [CNT_W-1:0]          rsp_fired_count,
   output logic signed [DUE_W-1:0]   rsp_next_due,
   output logic                      rsp_more_due,
   output logic                      rsp_last
);

`include "assert_macros.svh"

   localparam int PW = $clog2(CAPACITY);
   localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
   localparam logic [PW-1:0] LAST_POS = PW'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FIRE_LIM = CNT_W'(MAX_FIRE);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   function automatic logic [TIME_BITS-1:0] sat_in(input logic [IN_TIME_W-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      if ((w >> TIME_BITS) != 64'd0) return TIME_MAX;
      return w[TIME_BITS-1:0];
   endfunction

   // ring
   logic                 c_valid [CAPACITY];
   logic [ID_W-1:0]      c_id    [CAPACITY];
   logic [TIME_BITS-1:0] c_exp   [CAPACITY];
   logic [TIME_BITS-1:0] c_per   [CAPACITY];
   logic                 h_valid;
   logic [ID_W-1:0]      h_id;
   logic [TIME_BITS-1:0] h_exp;
   logic [TIME_BITS-1:0] h_per;
   logic                 shift;

   // control
   logic [1:0]        state_ff, state_in;
   logic [PW-1:0]     pos_ff, pos_in;
   logic              found_ff, found_in;
   logic              best_v_ff, best_v_in;
   logic              pend_v_ff, pend_v_in;
   logic [CNT_W-1:0]  fired_ff, fired_in;
   logic [ID_W-1:0]   id_ctr_ff, id_ctr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload
   logic [FUNC_W-1:0]    op_ff;
   logic [ID_W-1:0]      key_ff;
   logic [TIME_BITS-1:0] add_exp_ff, add_per_ff, now_ff;
   logic [TIME_BITS-1:0] best_exp_ff, best_exp_in;
   logic [ID_W-1:0]      best_id_ff, best_id_in;
   logic [PW-1:0]        best_tag_ff, best_tag_in;
   logic [PW-1:0]        pend_tag_ff, pend_tag_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [ID_W-1:0]      rid_ff, rid_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DUE_W-1:0]     due_ff, due_in;
   logic                 more_ff, more_in;
   logic                 last_ff, last_in;

   logic                 accept;
   logic                 out_free;
   logic                 load_rsp;
   logic                 take;
   logic                 better;
   logic                 due_now;
   logic [TIME_BITS:0]   re_sum;
   logic [63:0]          best_ext;

   assign shift = (state_ff == S_SCAN);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_ring
      if (i == CAPACITY - 1) begin : g_tail
         tmq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .d_valid(h_valid), .d_id(h_id), .d_exp(h_exp), .d_per(h_per),
            .q_valid(c_valid[i]), .q_id(c_id[i]), .q_exp(c_exp[i]), .q_per(c_per[i])
         );
      end else begin : g_mid
         tmq_cell #(.TIME_BITS(TIME_BITS)) u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .d_valid(c_valid[i+1]), .d_id(c_id[i+1]), .d_exp(c_exp[i+1]),
            .d_per(c_per[i+1]),
            .q_valid(c_valid[i]), .q_id(c_id[i]), .q_exp(c_exp[i]), .q_per(c_per[i])
         );
      end
   end

   // head stage: slot pos_ff sits in cell 0
   always_comb begin
      h_valid = c_valid[0];
      h_id    = c_id[0];
      h_exp   = c_exp[0];
      h_per   = c_per[0];
      take    = 1'b0;
      re_sum  = {1'b0, c_exp[0]} + {1'b0, c_per[0]};
      unique case (op_ff)
         FUNC_ADD: begin
            if (!found_ff && !c_valid[0]) begin
               h_valid = 1'b1;
               h_id    = id_ctr_ff;
               h_exp   = add_exp_ff;
               h_per   = add_per_ff;
               take    = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (!found_ff && c_valid[0] && c_id[0] == key_ff) begin
               h_valid = 1'b0;
               take    = 1'b1;
            end
         end
         FUNC_EXPIRE: begin
            // re-arm or retire the timer fired on the previous turn
            if (pend_v_ff && pos_ff == pend_tag_ff) begin
               if (c_per[0] != '0) begin
                  h_exp = re_sum[TIME_BITS] ? TIME_MAX : re_sum[TIME_BITS-1:0];
               end else begin
                  h_valid = 1'b0;
               end
            end
         end
         default: ;
      endcase
      better = h_valid && (!best_v_ff || h_exp < best_exp_ff ||
                           (h_exp == best_exp_ff && h_id < best_id_ff));
   end

   assign accept   = (state_ff == S_IDLE) && req_valid;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load_rsp = (state_ff == S_EMIT) && out_free;
   assign due_now  = best_v_ff && (best_exp_ff <= now_ff);
   assign best_ext = 64'(best_exp_ff);

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      found_in    = found_ff;
      best_v_in   = best_v_ff;
      best_exp_in = best_exp_ff;
      best_id_in  = best_id_ff;
      best_tag_in = best_tag_ff;
      pend_v_in   = pend_v_ff;
      pend_tag_in = pend_tag_ff;
      fired_in    = fired_ff;
      id_ctr_in   = id_ctr_ff;
      kind_in     = kind_ff;
      rid_in      = rid_ff;
      cnt_in      = cnt_ff;
      due_in      = due_ff;
      more_in     = more_ff;
      last_in     = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = '0;
               found_in  = 1'b0;
               best_v_in = 1'b0;
               pend_v_in = 1'b0;
               fired_in  = '0;
               if (req_func == FUNC_ADD || req_func == FUNC_REMOVE ||
                   req_func == FUNC_EXPIRE) begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            found_in = found_ff | take;
            if (better) begin
               best_v_in   = 1'b1;
               best_exp_in = h_exp;
               best_id_in  = h_id;
               best_tag_in = pos_ff;
            end
            if (pos_ff == LAST_POS) begin
               pos_in   = '0;
               state_in = S_EMIT;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rid_in   = '0;
               cnt_in   = '0;
               due_in   = '0;
               more_in  = 1'b0;
               last_in  = 1'b1;
               state_in = S_IDLE;
               unique case (op_ff)
                  FUNC_ADD: begin
                     kind_in = found_ff ? KIND_ADDED : KIND_FULL;
                     if (found_ff) begin
                        rid_in    = id_ctr_ff;
                        id_ctr_in = (id_ctr_ff + 1'b1 == '0) ? ID_W'(1) : id_ctr_ff + 1'b1;
                     end
                  end
                  FUNC_REMOVE: begin
                     kind_in = found_ff ? KIND_REMOVED : KIND_NOT_FOUND;
                  end
                  default: begin
                     if (fired_ff < FIRE_LIM && due_now) begin
                        kind_in     = KIND_FIRED;
                        rid_in      = best_id_ff;
                        last_in     = 1'b0;
                        fired_in    = fired_ff + 1'b1;
                        pend_v_in   = 1'b1;
                        pend_tag_in = best_tag_ff;
                        best_v_in   = 1'b0;
                        state_in    = S_SCAN;
                     end else begin
                        kind_in = KIND_SUMMARY;
                        cnt_in  = fired_ff;
                        due_in  = best_v_ff ? best_ext[DUE_W-1:0] : {DUE_W{1'b1}};
                        more_in = (fired_ff >= FIRE_LIM) && due_now;
                     end
                  end
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         best_v_ff    <= 1'b0;
         pend_v_ff    <= 1'b0;
         fired_ff     <= '0;
         id_ctr_ff    <= ID_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         found_ff     <= found_in;
         best_v_ff    <= best_v_in;
         pend_v_ff    <= pend_v_in;
         fired_ff     <= fired_in;
         id_ctr_ff    <= id_ctr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_func;
         key_ff     <= req_timer_key;
         add_exp_ff <= sat_in(req_expiry_time);
         add_per_ff <= sat_in(req_period);
         now_ff     <= sat_in(req_now_time);
      end
      best_exp_ff <= best_exp_in;
      best_id_ff  <= best_id_in;
      best_tag_ff <= best_tag_in;
      pend_tag_ff <= pend_tag_in;
      kind_ff     <= kind_in;
      rid_ff      <= rid_in;
      cnt_ff      <= cnt_in;
      due_ff      <= due_in;
      more_ff     <= more_in;
      last_ff     <= last_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_result_id   = rid_ff;
   assign rsp_fired_count = cnt_ff;
   assign rsp_next_due    = due_ff;
   assign rsp_more_due    = more_ff;
   assign rsp_last        = last_ff;

   `ASSERT_IMPLY(a_fire_limit, clock, reset, 1'b1, fired_ff <= FIRE_LIM)
   `ASSERT_IMPLY(a_fired_not_last, clock, reset, rsp_valid_ff && kind_ff == KIND_FIRED, !last_ff)
   `ASSERT_IMPLY(a_summary_last, clock, reset, rsp_valid_ff && kind_ff == KIND_SUMMARY, last_ff)
   `ASSERT_NEXT(a_scan_steps, clock, reset, state_ff == S_SCAN && pos_ff != LAST_POS,
                state_ff == S_SCAN && pos_ff == $past(pos_ff) + 1'b1)

endmodule

`default_nettype wire

// File: bench/timer_expiry_queue_tb.sv
// Self-checking bench for timer_expiry_queue: random and directed add, remove and
// expire requests, checked against an in-bench timer table model.
// Depends on tmq_pkg and the timer_expiry_queue RTL.
`timescale 1ns / 1ps
`default_nettype none

module timer_expiry_queue_tb;
   import tmq_pkg::*;

   localparam int SLOTS = CAPACITY_DEF;
   localparam int FIRE_LIMIT = MAX_FIRE_DEF;
   localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [FUNC_W-1:0] FUNC_BAD = 2'd3;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [47:0] expiry;
      logic [47:0] period;
      logic [31:0] key;
      logic [47:0] now;
   } timer_req_t;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [31:0] id;
      logic [5:0] cnt;
      logic [48:0] due;
      logic more;
      logic last;
   } timer_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [FUNC_W-1:0] req_func = '0;
   logic [47:0] req_expiry_time = '0;
   logic [47:0] req_period = '0;
   logic [31:0] req_timer_key = '0;
   logic [47:0] req_now_time = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [31:0] rsp_result_id;
   logic [5:0] rsp_fired_count;
   logic signed [48:0] rsp_next_due;
   logic rsp_more_due;
   logic rsp_last;

   timer_expiry_queue dut (.*);

   always #5 clock = ~clock;

   // timer table copy
   bit tbl_valid [SLOTS];
   logic [31:0] tbl_id [SLOTS];
   logic [47:0] tbl_exp [SLOTS];
   logic [47:0] tbl_per [SLOTS];
   logic [31:0] next_id = 32'd1;

   timer_req_t pending_reqs[$];
   timer_rsp_t expected_rsps[$];
   int errors = 0, mismatches = 0, idle_cycles = 0;
   int n_sent = 0, n_rsp = 0, n_fired = 0, n_full = 0;
   bit noidle = 1'b0, hold_rsp = 1'b0;
   int rsp_hold_cnt = 0, req_gap = 0, rsp_gap = 0;

   function automatic int earliest_slot();
      int best = -1;
      for (int i = 0; i < SLOTS; i++) begin
         if (!tbl_valid[i]) continue;
         if (best < 0 || tbl_exp[i] < tbl_exp[best] ||
             (tbl_exp[i] == tbl_exp[best] && tbl_id[i] < tbl_id[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic timer_rsp_t mk(logic [KIND_W-1:0] k, logic [31:0] id,
                                     logic [5:0] c, logic [48:0] d, logic m, logic l);
      timer_rsp_t r;
      r.kind = k; r.id = id; r.cnt = c; r.due = d; r.more = m; r.last = l;
      return r;
   endfunction

   task automatic predict_timer_op(timer_req_t q);
      int slot, fired;
      logic more;
      slot = -1;
      fired = 0;
      more = 1'b0;
      case (q.func)
         FUNC_ADD: begin
            for (int i = 0; i < SLOTS; i++)
               if (!tbl_valid[i] && slot < 0) slot = i;
            if (slot < 0) begin
               expected_rsps.push_back(mk(KIND_FULL, 0, 0, 0, 0, 1));
            end else begin
               tbl_valid[slot] = 1'b1;
               tbl_id[slot] = next_id;
               tbl_exp[slot] = q.expiry;
               tbl_per[slot] = q.period;
               expected_rsps.push_back(mk(KIND_ADDED, next_id, 0, 0, 0, 1));
               next_id = next_id + 1;
               if (next_id == 0) next_id = 1;
            end
         end
         FUNC_REMOVE: begin
            for (int i = 0; i < SLOTS; i++)
               if (slot < 0 && tbl_valid[i] && tbl_id[i] == q.key) slot = i;
            if (slot >= 0) tbl_valid[slot] = 1'b0;
            expected_rsps.push_back(mk(slot >= 0 ? KIND_REMOVED : KIND_NOT_FOUND,
                                       0, 0, 0, 0, 1));
         end
         FUNC_EXPIRE: begin
            while (fired < FIRE_LIMIT) begin
               slot = earliest_slot();
               if (slot < 0 || tbl_exp[slot] > q.now) break;
               expected_rsps.push_back(mk(KIND_FIRED, tbl_id[slot], 0, 0, 0, 0));
               fired++;
               if (tbl_per[slot] != 0)
                  tbl_exp[slot] = (tbl_per[slot] > TMAX - tbl_exp[slot]) ? TMAX
                                  : tbl_exp[slot] + tbl_per[slot];
               else
                  tbl_valid[slot] = 1'b0;
            end
            slot = earliest_slot();
            if (slot >= 0 && fired >= FIRE_LIMIT && tbl_exp[slot] <= q.now) more = 1'b1;
            expected_rsps.push_back(mk(KIND_SUMMARY, 0, fired[5:0],
                                       slot < 0 ? {49{1'b1}} : {1'b0, tbl_exp[slot]},
                                       more, 1));
         end
         default: ;
      endcase
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) n_sent <= n_sent + 1;
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            timer_req_t q;
            q = pending_reqs.pop_front();
            predict_timer_op(q);
            req_valid <= 1'b1;
            req_func <= q.func;
            req_expiry_time <= q.expiry;
            req_period <= q.period;
            req_timer_key <= q.key;
            req_now_time <= q.now;
            if (!noidle && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 16);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            timer_rsp_t got;
            got = mk(rsp_kind, rsp_result_id, rsp_fired_count, rsp_next_due,
                     rsp_more_due, rsp_last);
            n_rsp <= n_rsp + 1;
            if (rsp_kind == KIND_FIRED) n_fired <= n_fired + 1;
            if (rsp_kind == KIND_FULL) n_full <= n_full + 1;
            if (expected_rsps.size() == 0) begin
               errors++;
               if (mismatches++ < 10) $display("unexpected result %p", got);
            end else begin
               timer_rsp_t exp_r;
               exp_r = expected_rsps.pop_front();
               if (got !== exp_r) begin
                  errors++;
                  if (mismatches++ < 10)
                     $display("mismatch: expected %p got %p", exp_r, got);
               end
            end
         end
         if (hold_rsp) begin
            rsp_hold_cnt <= rsp_hold_cnt + 1;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!noidle && $urandom_range(0, 6) == 0) rsp_gap <= $urandom_range(1, 16);
         end
      end
   end

   // watchdog: no transfer for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("timeout, %0d results outstanding", expected_rsps.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic timer_req_t op(logic [FUNC_W-1:0] f, logic [47:0] e,
                                     logic [47:0] p, logic [31:0] k, logic [47:0] n);
      timer_req_t q;
      q.func = f; q.expiry = e; q.period = p; q.key = k; q.now = n;
      return q;
   endfunction

   function automatic logic [47:0] rand_time();
      case ($urandom_range(0, 3))
         0: return 48'({$urandom, $urandom});
         1: return TMAX - 48'($urandom_range(0, 3));
         default: return 48'($urandom_range(0, 2000));
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (3 * (FIRE_LIMIT + 2) * (SLOTS + 2)) @(posedge clock);
   endtask

   initial begin
      logic [31:0] key;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty expire, extremes, full table, duplicates in time, bad func
      pending_reqs.push_back(op(FUNC_EXPIRE, 0, 0, 0, TMAX));
      pending_reqs.push_back(op(FUNC_REMOVE, 0, 0, 32'hFFFF_FFFF, 0));
      pending_reqs.push_back(op(FUNC_ADD, TMAX, TMAX, 0, 0));
      pending_reqs.push_back(op(FUNC_ADD, 0, 0, 0, 0));
      pending_reqs.push_back(op(FUNC_ADD, 5, 5, 0, 0));
      pending_reqs.push_back(op(FUNC_ADD, 5, 0, 0, 0));
      pending_reqs.push_back(op(FUNC_BAD, TMAX, TMAX, 32'hFFFF_FFFF, TMAX));
      pending_reqs.push_back(op(FUNC_REMOVE, 0, 0, 2, 0));
      pending_reqs.push_back(op(FUNC_EXPIRE, 0, 0, 0, 20));
      for (int i = 0; i < 14; i++) pending_reqs.push_back(op(FUNC_ADD, 1, 1, 0, 0));
      // periodic period-1 timers hit the fire limit
      pending_reqs.push_back(op(FUNC_EXPIRE, 0, 0, 0, 100000));
      pending_reqs.push_back(op(FUNC_EXPIRE, 0, 0, 0, TMAX));
      wait_drained();

      // long receiver stall while sender keeps offering
      hold_rsp = 1'b1;
      for (int i = 0; i < 12; i++)
         pending_reqs.push_back(op(FUNC_REMOVE, 0, 0, $urandom_range(1, 40), 0));
      while (rsp_hold_cnt < 400) @(posedge clock);
      hold_rsp = 1'b0;
      wait_drained();

      // random phase: mostly adds and removes of live ids, some expires
      for (int i = 0; i < 73; i++) begin
         if (i == 55) begin
            wait_drained();
            noidle = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: pending_reqs.push_back(op(FUNC_ADD, rand_time(),
                            $urandom_range(0, 1) ? 48'd0 : rand_time(), 0, 0));
            4, 5: begin
               key = ($urandom_range(0, 4) == 0) ? $urandom
                     : next_id - $urandom_range(1, 20);
               pending_reqs.push_back(op(FUNC_REMOVE, {$urandom, $urandom}, 0, key, 0));
            end
            6: pending_reqs.push_back(op(FUNC_BAD, $urandom, $urandom, $urandom, $urandom));
            default: pending_reqs.push_back(op(FUNC_EXPIRE, $urandom, $urandom, $urandom,
                                               rand_time()));
         endcase
      end
      wait_drained();

      $display("Sent %0d requests, checked %0d results (%0d fired, %0d table full).",
               n_sent, n_rsp, n_fired, n_full);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
